### rtl/asgp_pkg.sv
package asgp_pkg;

   localparam int GROUP_SIZE = 4;
   localparam int FILL_W     = 2;
   localparam int IDX_W      = 3;

   localparam logic [FILL_W-1:0] LAST_POS = FILL_W'(GROUP_SIZE - 1);

   // One complete or frame-truncated group, handed from front to back.
   typedef struct packed {
      logic [7:0]                  header;
      logic [GROUP_SIZE-1:0][7:0]  high;
      logic [FILL_W-1:0]           last_pos;
      logic                        frame_end;
   } group_type;

endpackage

### rtl/asgp_front.sv
module asgp_front import asgp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [9:0] sample,
   input  logic       frame_last,
   output group_type  grp,
   output logic       grp_push
);

   logic [7:0]                 header_ff, header_in;
   logic [FILL_W-1:0]          fill_ff, fill_in;
   logic [GROUP_SIZE-1:0][7:0] high_ff, high_in;
   logic [7:0]                 hdr_merged;
   logic [GROUP_SIZE-1:0][7:0] high_merged;
   logic                       close;

   always_comb begin
      hdr_merged          = header_ff | (8'(sample[1:0]) << {fill_ff, 1'b0});
      high_merged         = high_ff;
      high_merged[fill_ff] = sample[9:2];
      close               = (fill_ff == LAST_POS) || frame_last;

      grp.header    = hdr_merged;
      grp.high      = high_merged;
      grp.last_pos  = fill_ff;
      grp.frame_end = frame_last;
      grp_push      = take && close;

      header_in = header_ff;
      fill_in   = fill_ff;
      high_in   = high_ff;
      if (take) begin
         high_in = high_merged;
         if (close) begin
            header_in = '0;
            fill_in   = '0;
         end else begin
            header_in = hdr_merged;
            fill_in   = fill_ff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         fill_ff   <= '0;
      end else begin
         header_ff <= header_in;
         fill_ff   <= fill_in;
      end
      high_ff <= high_in;
   end

endmodule

### rtl/asgp_queue.sv
module asgp_queue import asgp_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_grp,
   input  logic      pop,
   output group_type head,
   output logic      head_valid,
   output logic      full
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   group_type          slot_ff [DEPTH];
   group_type          slot_in [DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   wr_idx;

   assign head       = slot_ff[0];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      // Shift towards the head on a pop; write behind the last live entry.
      wr_idx = count_ff - CNT_W'(pop);
      for (int i = 0; i < DEPTH; i++) begin
         if (pop && (i < DEPTH - 1)) begin
            slot_in[i] = slot_ff[(i < DEPTH - 1) ? i + 1 : i];
         end else begin
            slot_in[i] = slot_ff[i];
         end
         if (push && (wr_idx == CNT_W'(i))) begin
            slot_in[i] = push_grp;
         end
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

### rtl/asgp_back.sv
module asgp_back import asgp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  group_type  head,
   input  logic       head_valid,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end
);

   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [7:0]        byte_ff, byte_in;
   logic              end_ff, end_in;
   logic              load, take, final_beat;
   logic [FILL_W-1:0] sel;

   always_comb begin
      load       = !valid_ff || rsp_ready;
      take       = load && head_valid;
      sel        = FILL_W'(idx_ff - IDX_W'(1));
      final_beat = (idx_ff == (IDX_W'(head.last_pos) + IDX_W'(1)));
      pop        = take && final_beat;

      idx_in   = idx_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      valid_in = load ? 1'b0 : valid_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = (idx_ff == '0) ? head.header : head.high[sel];
         end_in   = final_beat && head.frame_end;
         idx_in   = final_beat ? '0 : idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      end_ff  <= end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_frame_end = end_ff;

endmodule

### rtl/adc_sample_group_packer_unit.sv
// channel  | direction | beat contents
// req_     | in        | sample (10 b), frame_last (1 b)
// rsp_     | out       | out_byte (8 b), frame_end (1 b)
//
// A sample beat is taken whenever req_valid and req_ready are both high; a group of up to
// four samples leaves as a header beat plus one beat per sample, at one beat per cycle while
// rsp_ready stays high, so a full group leaves as five output beats.
// The group queue (QUEUE_DEPTH entries) lets samples keep arriving while a finished
// group drains; req_ready drops only while the queue is full. Reset is synchronous and
// clears group fill, header accumulator, queue count, byte index and output valid.
module adc_sample_group_packer_unit import asgp_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [9:0] req_sample,
   input  logic       req_frame_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_end
);

   group_type grp, head;
   logic      grp_push, pop, head_valid, q_full, take;

   // Hold off new samples only while no room is left for a finished group.
   assign req_ready = !q_full;
   assign take      = req_valid && req_ready;

   // Front: gather low-bit pairs and high bytes; emit a group on close.
   asgp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .sample     (req_sample),
      .frame_last (req_frame_last),
      .grp        (grp),
      .grp_push   (grp_push)
   );

   // Queue between sample grouping and byte serialisation.
   asgp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (grp_push),
      .push_grp   (grp),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // Back: walk header then high bytes into the output register.
   asgp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### rtl/asgp_checker.sv
module asgp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_frame_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_frame_end
);

   logic seen_ff, seen_in;
   logic last_seen_ff, last_seen_in;

   assign seen_in      = seen_ff || (req_valid && req_ready);
   assign last_seen_in = last_seen_ff || (req_valid && req_ready && req_frame_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         last_seen_ff <= 1'b0;
      end else begin
         seen_ff      <= seen_in;
         last_seen_ff <= last_seen_in;
      end
   end

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_frame_end))
      else $error("stalled rsp beat changed");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> seen_ff)
      else $error("rsp beat with no sample taken");

   a_end_needs_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_end |-> last_seen_ff)
      else $error("frame end with no frame-last sample taken");

endmodule

bind adc_sample_group_packer_unit asgp_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_frame_last (req_frame_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_frame_end  (rsp_frame_end)
);
